/* rtl/smbe_pkg.sv */
// Shared types and constants for the stack machine bytecode executor.
`default_nettype none

package smbe_pkg;

   localparam int WORD_BITS_DEF   = 64;
   localparam int STACK_DEPTH_DEF = 1024;
   localparam int DEPTH_OUT_BITS  = 11;

   localparam logic [7:0] OP_STOP  = 8'h00;
   localparam logic [7:0] OP_ADD   = 8'h01;
   localparam logic [7:0] OP_MUL   = 8'h02;
   localparam logic [7:0] OP_SUB   = 8'h03;
   localparam logic [7:0] OP_DIV   = 8'h04;
   localparam logic [7:0] OP_MOD   = 8'h05;
   localparam logic [7:0] OP_PUSH1 = 8'h60;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_STOPPED   = 3'd1,
      ST_UNDERFLOW = 3'd2,
      ST_OVERFLOW  = 3'd3,
      ST_BADOP     = 3'd4,
      ST_TRUNC     = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV,
      ALU_MOD
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_DECODE,
      SEQ_READ,
      SEQ_WAIT,
      SEQ_WRITE
   } seq_state_type;

endpackage

`default_nettype wire

/* rtl/smbe_alu.sv */
// Shared arithmetic unit: add/sub, bit-serial multiply and restoring divide.
`default_nettype none

module smbe_alu #(
   parameter int WORD_BITS = smbe_pkg::WORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  smbe_pkg::alu_req_type alu_req,
   input  logic [WORD_BITS-1:0]  opnd_a,
   input  logic [WORD_BITS-1:0]  opnd_b,
   output logic                  alu_done,
   output logic [WORD_BITS-1:0]  alu_result
);
   import smbe_pkg::*;

   localparam int CNT_BITS = $clog2(WORD_BITS);

   logic                 busy_ff;
   logic                 done_ff;
   alu_op_type           op_ff;
   logic [CNT_BITS-1:0]  count_ff;
   logic [WORD_BITS-1:0] acc_ff;
   logic [WORD_BITS-1:0] opd_ff;
   logic [WORD_BITS-1:0] mcand_ff;

   logic [WORD_BITS:0]   add_x;
   logic [WORD_BITS:0]   add_y;
   logic                 add_sub;
   logic [WORD_BITS+1:0] add_sum;
   logic [WORD_BITS:0]   rem_sh;
   logic                 rem_ge;
   logic                 start_ok;

   assign start_ok = alu_req.start && !busy_ff;
   assign rem_sh   = {acc_ff, opd_ff[WORD_BITS-1]};

   // single adder shared by every operation
   always_comb begin
      add_x   = {1'b0, opnd_a};
      add_y   = {1'b0, opnd_b};
      add_sub = (alu_req.op == ALU_SUB);
      if (busy_ff) begin
         if (op_ff == ALU_MUL) begin
            add_x   = {1'b0, acc_ff};
            add_y   = {1'b0, mcand_ff};
            add_sub = 1'b0;
         end else begin
            add_x   = rem_sh;
            add_y   = {1'b0, mcand_ff};
            add_sub = 1'b1;
         end
      end
   end

   assign add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                    + (WORD_BITS+2)'(add_sub);
   // carry out of the subtract means no borrow
   assign rem_ge  = add_sum[WORD_BITS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start_ok) begin
            case (alu_req.op)
               ALU_ADD, ALU_SUB: begin
                  done_ff <= 1'b1;
               end
               default: begin
                  busy_ff  <= 1'b1;
                  count_ff <= CNT_BITS'(WORD_BITS - 1);
               end
            endcase
         end else if (busy_ff) begin
            count_ff <= count_ff - CNT_BITS'(1);
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_ok) begin
         op_ff <= alu_req.op;
         case (alu_req.op)
            ALU_ADD, ALU_SUB: begin
               acc_ff <= add_sum[WORD_BITS-1:0];
            end
            ALU_MUL: begin
               acc_ff   <= '0;
               opd_ff   <= opnd_b;
               mcand_ff <= opnd_a;
            end
            default: begin
               acc_ff   <= '0;
               opd_ff   <= opnd_a;
               mcand_ff <= opnd_b;
            end
         endcase
      end else if (busy_ff) begin
         if (op_ff == ALU_MUL) begin
            if (opd_ff[0]) begin
               acc_ff <= add_sum[WORD_BITS-1:0];
            end
            mcand_ff <= {mcand_ff[WORD_BITS-2:0], 1'b0};
            opd_ff   <= {1'b0, opd_ff[WORD_BITS-1:1]};
         end else begin
            acc_ff <= rem_ge ? add_sum[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
            opd_ff <= {opd_ff[WORD_BITS-2:0], rem_ge};
         end
      end
   end

   assign alu_done   = done_ff;
   assign alu_result = (op_ff == ALU_DIV) ? opd_ff : acc_ff;

endmodule

`default_nettype wire

/* rtl/stack_machine_bytecode_executor_unit.sv */
// Top level: byte sequencer, stack memory and cached top of stack around the shared ALU.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready  code_byte, end_of_code
//   rsp_     out        rsp_valid/rsp_ready  status, top_value, stack_depth
//
// PUSH1, its immediate, STOP, errors and bytes after a halt commit straight from decode.
// ADD and SUB use the adder once; for MUL, DIV and MOD the ALU retires one bit a cycle.
// DIV/MOD by zero skip the ALU and give zero. The stack read is registered.
// Synchronous reset clears depth, halt and immediate flag; the stack memory is not cleared.
// A result waiting in the output register holds the sequencer before its next commit.
`default_nettype none

module stack_machine_bytecode_executor_unit #(
   parameter int STACK_DEPTH = smbe_pkg::STACK_DEPTH_DEF,
   parameter int WORD_BITS   = smbe_pkg::WORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_code_byte,
   input  logic                                req_end_of_code,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [2:0]                          rsp_status,
   output logic [WORD_BITS-1:0]                rsp_top_value,
   output logic [smbe_pkg::DEPTH_OUT_BITS-1:0] rsp_stack_depth
);
   import smbe_pkg::*;

   localparam int ADDR_BITS  = $clog2(STACK_DEPTH);
   localparam int DEPTH_BITS = $clog2(STACK_DEPTH + 1);

   seq_state_type            state_ff, state_in;
   logic [DEPTH_BITS-1:0]    depth_ff, depth_in;
   logic [WORD_BITS-1:0]     top_ff, top_in;
   logic                     await_ff, await_in;
   status_type               halt_ff, halt_in;
   logic [7:0]               byte_ff, byte_in;
   logic                     last_ff, last_in;
   alu_op_type               op_ff, op_in;
   logic [WORD_BITS-1:0]     res_ff, res_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [2:0]               rsp_status_ff, rsp_status_in;
   logic [WORD_BITS-1:0]     rsp_top_ff, rsp_top_in;
   logic [DEPTH_OUT_BITS-1:0] rsp_depth_ff, rsp_depth_in;

   logic [WORD_BITS-1:0]     stack_mem [STACK_DEPTH];
   logic [WORD_BITS-1:0]     rd_data_ff;
   logic                     mem_we, mem_re;
   logic [ADDR_BITS-1:0]     mem_waddr, mem_raddr;
   logic [WORD_BITS-1:0]     mem_wdata;

   logic [DEPTH_BITS-1:0]    below_idx;
   logic                     out_free;
   logic                     commit;
   alu_req_type              alu_req;
   logic                     alu_done;
   logic [WORD_BITS-1:0]     alu_result;

   smbe_alu #(
      .WORD_BITS(WORD_BITS)
   ) u_alu (
      .clock      (clock),
      .reset      (reset),
      .alu_req    (alu_req),
      .opnd_a     (top_ff),
      .opnd_b     (rd_data_ff),
      .alu_done   (alu_done),
      .alu_result (alu_result)
   );

   assign below_idx = depth_ff - DEPTH_BITS'(2);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == SEQ_IDLE);

   always_comb begin
      state_in   = state_ff;
      depth_in   = depth_ff;
      top_in     = top_ff;
      await_in   = await_ff;
      halt_in    = halt_ff;
      byte_in    = byte_ff;
      last_in    = last_ff;
      op_in      = op_ff;
      res_in     = res_ff;
      commit     = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_waddr  = depth_ff[ADDR_BITS-1:0];
      mem_raddr  = below_idx[ADDR_BITS-1:0];
      mem_wdata  = WORD_BITS'(byte_ff);
      alu_req.start = 1'b0;
      alu_req.op    = op_ff;

      case (state_ff)
         SEQ_IDLE: begin
            if (req_valid) begin
               byte_in  = req_code_byte;
               last_in  = req_end_of_code;
               state_in = SEQ_DECODE;
            end
         end
         SEQ_DECODE: begin
            if (halt_ff != ST_OK) begin
               commit = out_free;
            end else if (await_ff) begin
               // immediate byte is data, whatever its value
               commit = out_free;
               if (commit) begin
                  await_in = 1'b0;
                  if (depth_ff >= DEPTH_BITS'(STACK_DEPTH)) begin
                     halt_in = ST_OVERFLOW;
                  end else begin
                     mem_we   = 1'b1;
                     top_in   = WORD_BITS'(byte_ff);
                     depth_in = depth_ff + DEPTH_BITS'(1);
                  end
               end
            end else begin
               case (byte_ff)
                  OP_STOP: begin
                     commit = out_free;
                     if (commit) halt_in = ST_STOPPED;
                  end
                  OP_PUSH1: begin
                     commit = out_free;
                     if (commit) begin
                        if (last_ff) halt_in = ST_TRUNC;
                        else await_in = 1'b1;
                     end
                  end
                  OP_ADD, OP_MUL, OP_SUB, OP_DIV, OP_MOD: begin
                     case (byte_ff)
                        OP_ADD:  op_in = ALU_ADD;
                        OP_MUL:  op_in = ALU_MUL;
                        OP_SUB:  op_in = ALU_SUB;
                        OP_DIV:  op_in = ALU_DIV;
                        default: op_in = ALU_MOD;
                     endcase
                     if (depth_ff < DEPTH_BITS'(2)) begin
                        commit = out_free;
                        if (commit) halt_in = ST_UNDERFLOW;
                     end else begin
                        mem_re   = 1'b1;
                        state_in = SEQ_READ;
                     end
                  end
                  default: begin
                     commit = out_free;
                     if (commit) halt_in = ST_BADOP;
                  end
               endcase
            end
            if (commit) state_in = SEQ_IDLE;
         end
         SEQ_READ: begin
            if ((op_ff == ALU_DIV || op_ff == ALU_MOD) && rd_data_ff == '0) begin
               res_in   = '0;
               state_in = SEQ_WRITE;
            end else begin
               alu_req.start = 1'b1;
               state_in      = SEQ_WAIT;
            end
         end
         SEQ_WAIT: begin
            if (alu_done) begin
               res_in   = alu_result;
               state_in = SEQ_WRITE;
            end
         end
         SEQ_WRITE: begin
            commit = out_free;
            if (commit) begin
               mem_we    = 1'b1;
               mem_waddr = below_idx[ADDR_BITS-1:0];
               mem_wdata = res_ff;
               top_in    = res_ff;
               depth_in  = depth_ff - DEPTH_BITS'(1);
               state_in  = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_depth_in  = rsp_depth_ff;
      if (commit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = halt_in;
         rsp_top_in    = (depth_in == '0) ? '0 : top_in;
         rsp_depth_in  = DEPTH_OUT_BITS'(depth_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         depth_ff     <= '0;
         await_ff     <= 1'b0;
         halt_ff      <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         await_ff     <= await_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff        <= top_in;
      byte_ff       <= byte_in;
      last_ff       <= last_in;
      op_ff         <= op_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   // stack memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= stack_mem[mem_raddr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_top_value   = rsp_top_ff;
   assign rsp_stack_depth = rsp_depth_ff;

endmodule

`default_nettype wire
